[rtl/tlrr_pkg.sv]
package tlrr_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned SLICE_W = 8;

  localparam logic [SLICE_W-1:0] RESET_SLICE = 8'd3;
  localparam logic [TIME_W-1:0]  TIME_MAX    = 16'hFFFF;
  localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'hFF;

  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;
  localparam logic CLS_HIGH    = 1'b0;
  localparam logic CLS_LOW     = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_IDLE_TCK = 3'd2,
    ST_RAN      = 3'd3,
    ST_FINISHED = 3'd4
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   job_id;
    logic              job_class;
    logic [TIME_W-1:0] burst_length;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   ran_id;
    logic              ran_class;
    logic [TIME_W-1:0] now_time;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround;
  } out_item_t;

  // one queue entry, 56 bits
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remain;
  } job_entry_t;

endpackage

[rtl/tlrr_job_mem.sv]
module tlrr_job_mem #(
  parameter int unsigned AW = 7
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  tlrr_pkg::job_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output tlrr_pkg::job_entry_t rd_data
);
  import tlrr_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;

  job_entry_t mem [DEPTH];
  job_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/two_level_round_robin_scheduler_core.sv]
// Two-class round-robin job scheduler. Jobs arrive as items with req_type
// arrival and are appended to the high or low ring queue, stamped with the
// current time; an arrival to a full queue is dropped with status dropped.
// A tick item advances time by one unit (saturating at 65535) and runs that
// unit for the head of the high queue, or of the low queue when the high
// queue is empty. A head that has run slice_length consecutive units is
// rotated to its own tail; a finishing job leaves its queue and reports wait
// and turnaround times. Both queues share one synchronous job memory with a
// registered read. An arrival or an idle tick is answered straight from the
// idle state; a tick that runs a job reads the head entry from the memory,
// then, unless the job finishes, writes it back in place or at the tail.
// Every item gives exactly one result item. slice_length may be written only
// while no item is in flight; zero acts as one.
module two_level_round_robin_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  tlrr_pkg::in_item_t  in_item,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output tlrr_pkg::out_item_t out_item,
  // slice length register
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import tlrr_pkg::*;

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned AW = IW + 1;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_RUN  = 2'b10
  } fsm_t;

  fsm_t fsm_r, fsm_nxt;

  // queue pointers
  logic [IW-1:0] hi_head_r, hi_head_nxt, lo_head_r, lo_head_nxt;
  logic [CW-1:0] hi_cnt_r, hi_cnt_nxt, lo_cnt_r, lo_cnt_nxt;

  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [SLICE_W-1:0] slice_used_r, slice_used_nxt;
  logic [SLICE_W-1:0] slice_len_r;

  // last job that ran, for the slice restart rule
  logic               last_vld_r, last_vld_nxt;
  logic               last_cls_r, last_cls_nxt;
  logic [ID_W-1:0]    last_id_r, last_id_nxt;

  logic               run_cls_r, run_cls_nxt;

  logic               out_vld_r, out_vld_nxt;
  out_item_t          out_item_r, out_item_nxt;

  // memory port signals
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  job_entry_t         mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  job_entry_t         mem_rdata;

  // selected queue views
  logic               sel_cls;
  logic [IW-1:0]      sel_head;
  logic [CW-1:0]      sel_cnt;
  logic [SW-1:0]      tail_sum;
  logic [IW-1:0]      tail_idx;
  logic [IW-1:0]      head_inc;

  logic               accept;
  logic [TIME_W-1:0]  time_inc;

  // run stage values
  logic               same_job;
  logic [SLICE_W-1:0] su_base, su_inc;
  logic [TIME_W-1:0]  remain_new, tat, wait_t;
  logic               finish, rotate;

  tlrr_job_mem #(
    .AW(AW)
  ) u_job_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // new item only from idle, and only when the result slot frees up
  assign in_ready  = (fsm_r == FSM_IDLE) && (!out_vld_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  assign time_inc = (time_r == TIME_MAX) ? TIME_MAX : time_r + 1'b1;

  // queue selection: arrival uses its class, tick picks high first,
  // run stage uses the class latched at accept
  always_comb begin
    if (fsm_r == FSM_RUN) begin
      sel_cls = run_cls_r;
    end else if (in_item.req_type == REQ_ARRIVAL) begin
      sel_cls = in_item.job_class;
    end else begin
      sel_cls = (hi_cnt_r != '0) ? CLS_HIGH : CLS_LOW;
    end
    sel_head = (sel_cls == CLS_LOW) ? lo_head_r : hi_head_r;
    sel_cnt  = (sel_cls == CLS_LOW) ? lo_cnt_r  : hi_cnt_r;
  end

  // ring arithmetic, valid for any depth
  assign tail_sum = SW'(sel_head) + SW'(sel_cnt);
  assign tail_idx = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : IW'(tail_sum);
  assign head_inc = (sel_head == IW'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;

  // run stage arithmetic on the head entry read last cycle
  always_comb begin
    same_job   = last_vld_r && (last_cls_r == run_cls_r) && (last_id_r == mem_rdata.id);
    su_base    = same_job ? slice_used_r : '0;
    su_inc     = (su_base == SLICE_MAX) ? SLICE_MAX : su_base + 1'b1;
    remain_new = (mem_rdata.remain != '0) ? mem_rdata.remain - 1'b1 : '0;
    finish     = (remain_new == '0);
    rotate     = !finish && (su_inc >= slice_len_r);
    tat        = time_r - mem_rdata.arrival;
    wait_t     = (tat >= mem_rdata.burst) ? tat - mem_rdata.burst : '0;
  end

  always_comb begin
    fsm_nxt        = fsm_r;
    hi_head_nxt    = hi_head_r;
    lo_head_nxt    = lo_head_r;
    hi_cnt_nxt     = hi_cnt_r;
    lo_cnt_nxt     = lo_cnt_r;
    time_nxt       = time_r;
    slice_used_nxt = slice_used_r;
    last_vld_nxt   = last_vld_r;
    last_cls_nxt   = last_cls_r;
    last_id_nxt    = last_id_r;
    run_cls_nxt    = run_cls_r;
    out_vld_nxt    = out_vld_r && !out_ready;
    out_item_nxt   = out_item_r;

    mem_we         = 1'b0;
    mem_waddr      = {sel_cls, tail_idx};
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = {sel_cls, sel_head};

    unique case (fsm_r)
      FSM_IDLE: begin
        if (accept) begin
          out_item_nxt            = '0;
          out_vld_nxt             = 1'b1;
          if (in_item.req_type == REQ_ARRIVAL) begin
            out_item_nxt.now_time = time_r;
            if (sel_cnt == CW'(QUEUE_DEPTH)) begin
              out_item_nxt.status = ST_DROPPED;
            end else begin
              out_item_nxt.status = ST_ACCEPTED;
              mem_we              = 1'b1;
              mem_wdata.id        = in_item.job_id;
              mem_wdata.arrival   = time_r;
              mem_wdata.burst     = in_item.burst_length;
              mem_wdata.remain    = in_item.burst_length;
              if (sel_cls == CLS_LOW) begin
                lo_cnt_nxt = lo_cnt_r + 1'b1;
              end else begin
                hi_cnt_nxt = hi_cnt_r + 1'b1;
              end
            end
          end else begin
            time_nxt              = time_inc;
            out_item_nxt.now_time = time_inc;
            if (sel_cnt == '0) begin
              out_item_nxt.status = ST_IDLE_TCK;
            end else begin
              // head read now, result shows after the run cycle
              out_vld_nxt = 1'b0;
              mem_re      = 1'b1;
              run_cls_nxt = sel_cls;
              fsm_nxt     = FSM_RUN;
            end
          end
        end
      end

      FSM_RUN: begin
        fsm_nxt                 = FSM_IDLE;
        out_vld_nxt             = 1'b1;
        out_item_nxt.ran_id     = mem_rdata.id;
        out_item_nxt.ran_class  = run_cls_r;
        out_item_nxt.now_time   = time_r;
        out_item_nxt.wait_time  = '0;
        out_item_nxt.turnaround = '0;
        mem_wdata               = mem_rdata;
        mem_wdata.remain        = remain_new;
        if (finish) begin
          out_item_nxt.status     = ST_FINISHED;
          out_item_nxt.wait_time  = wait_t;
          out_item_nxt.turnaround = tat;
          slice_used_nxt          = '0;
          last_vld_nxt            = 1'b0;
          if (run_cls_r == CLS_LOW) begin
            lo_head_nxt = head_inc;
            lo_cnt_nxt  = lo_cnt_r - 1'b1;
          end else begin
            hi_head_nxt = head_inc;
            hi_cnt_nxt  = hi_cnt_r - 1'b1;
          end
        end else begin
          out_item_nxt.status = ST_RAN;
          mem_we              = 1'b1;
          if (rotate) begin
            // copy to tail; on a full ring the tail is the head slot itself
            slice_used_nxt = '0;
            last_vld_nxt   = 1'b0;
            if (run_cls_r == CLS_LOW) begin
              lo_head_nxt = head_inc;
            end else begin
              hi_head_nxt = head_inc;
            end
          end else begin
            mem_waddr      = {run_cls_r, sel_head};
            slice_used_nxt = su_inc;
            last_vld_nxt   = 1'b1;
            last_cls_nxt   = run_cls_r;
            last_id_nxt    = mem_rdata.id;
          end
        end
      end

      default: begin
        fsm_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= FSM_IDLE;
      hi_head_r    <= '0;
      lo_head_r    <= '0;
      hi_cnt_r     <= '0;
      lo_cnt_r     <= '0;
      time_r       <= '0;
      slice_used_r <= '0;
      last_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      slice_len_r  <= RESET_SLICE;
    end else begin
      fsm_r        <= fsm_nxt;
      hi_head_r    <= hi_head_nxt;
      lo_head_r    <= lo_head_nxt;
      hi_cnt_r     <= hi_cnt_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
      time_r       <= time_nxt;
      slice_used_r <= slice_used_nxt;
      last_vld_r   <= last_vld_nxt;
      out_vld_r    <= out_vld_nxt;
      if (cfg_we) begin
        slice_len_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    last_cls_r <= last_cls_nxt;
    last_id_r  <= last_id_nxt;
    run_cls_r  <= run_cls_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

[dv/tb_two_level_round_robin_scheduler_core.sv]
`timescale 1ns / 100ps

module tb_two_level_round_robin_scheduler_core;
  import tlrr_pkg::*;

  localparam int unsigned QDEPTH     = 64;
  // cycles with no item moving on either side before the run is abandoned
  localparam int unsigned STUCK_MAX  = 2000;
  // margin so that anything still in flight has settled
  localparam int unsigned SETTLE_CYC = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  two_level_round_robin_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // scheduler shadow: both ring queues, the clock and the slice bookkeeping
  // ---------------------------------------------------------------------------
  job_entry_t        job_mem [2][QDEPTH];
  int unsigned       q_head [2] = '{0, 0};
  int unsigned       q_cnt  [2] = '{0, 0};
  logic [TIME_W-1:0] sched_now   = '0;
  logic [7:0]        slice_run   = '0;
  logic              prev_valid  = 1'b0;
  logic              prev_class  = 1'b0;
  logic [ID_W-1:0]   prev_id     = '0;
  logic [7:0]        slice_len   = RESET_SLICE;

  // outcomes of accepted items, oldest first
  out_item_t   outcomes_due [$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;

  // apply one item to the shadow and return the outcome it must produce
  function automatic out_item_t run_scheduler(in_item_t it);
    out_item_t         r;
    job_entry_t        e;
    logic              c;
    logic [TIME_W-1:0] tat;
    r = '0;
    if (it.req_type == REQ_ARRIVAL) begin
      c = it.job_class;
      if (q_cnt[c] >= QDEPTH) begin
        // full queue, the job is dropped and nothing moves
        r.status = ST_DROPPED;
      end else begin
        e.id      = it.job_id;
        e.arrival = sched_now;
        e.burst   = it.burst_length;
        e.remain  = it.burst_length;
        job_mem[c][(q_head[c] + q_cnt[c]) % QDEPTH] = e;
        q_cnt[c]++;
        r.status = ST_ACCEPTED;
      end
    end else begin
      // time moves on every tick, idle or not, and sticks at the top
      if (sched_now != TIME_MAX) sched_now++;
      if (q_cnt[CLS_HIGH] == 0 && q_cnt[CLS_LOW] == 0) begin
        r.status = ST_IDLE_TCK;
      end else begin
        c = (q_cnt[CLS_HIGH] != 0) ? CLS_HIGH : CLS_LOW;
        e = job_mem[c][q_head[c]];
        // slice count restarts whenever a different job gets the cpu
        if (!prev_valid || prev_class != c || prev_id != e.id) slice_run = '0;
        prev_valid = 1'b1;
        prev_class = c;
        prev_id    = e.id;
        if (slice_run != SLICE_MAX) slice_run++;
        // a zero burst still costs one unit
        if (e.remain != 0) e.remain--;
        r.ran_id    = e.id;
        r.ran_class = c;
        if (e.remain == 0) begin
          tat          = sched_now - e.arrival;
          r.turnaround = tat;
          // saturated time can leave turnaround shorter than the burst
          r.wait_time  = (tat >= e.burst) ? tat - e.burst : '0;
          q_head[c]    = (q_head[c] + 1) % QDEPTH;
          q_cnt[c]--;
          slice_run    = '0;
          prev_valid   = 1'b0;
          r.status     = ST_FINISHED;
        end else begin
          job_mem[c][q_head[c]] = e;
          // slice used up (zero acts as one): head goes to its own tail
          if (slice_run >= slice_len) begin
            job_mem[c][(q_head[c] + q_cnt[c]) % QDEPTH] = e;
            q_head[c]  = (q_head[c] + 1) % QDEPTH;
            slice_run  = '0;
            prev_valid = 1'b0;
          end
          r.status = ST_RAN;
        end
      end
    end
    r.now_time = sched_now;
    return r;
  endfunction

  function automatic string describe_outcome(out_item_t r);
    return $sformatf("status=%0d id=%0d class=%0d now=%0d wait=%0d tat=%0d",
                     r.status, r.ran_id, r.ran_class, r.now_time, r.wait_time,
                     r.turnaround);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t arrival_item(logic [ID_W-1:0] id, logic cls,
                                            logic [TIME_W-1:0] burst);
    in_item_t it;
    it.req_type     = REQ_ARRIVAL;
    it.job_id       = id;
    it.job_class    = cls;
    it.burst_length = burst;
    return it;
  endfunction

  // the job fields of a tick are don't-care, so fill them with noise
  function automatic in_item_t tick_item();
    in_item_t it;
    it.req_type     = REQ_TICK;
    it.job_id       = ID_W'($urandom_range(0, 255));
    it.job_class    = 1'($urandom_range(0, 1));
    it.burst_length = TIME_W'($urandom_range(0, 65535));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: valid stays up between back-to-back items, drops only for a gap
  // ---------------------------------------------------------------------------
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    outcomes_due.push_back(run_scheduler(it));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slice_len = value;
  endtask

  task automatic drain_queues();
    while (q_cnt[CLS_HIGH] + q_cnt[CLS_LOW] != 0) send_item(tick_item());
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, with runs of steady ready in between
  // ---------------------------------------------------------------------------
  int unsigned ready_hold = 0;

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // compare each returned item against the oldest outcome still owed
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (outcomes_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: result %0d arrived with none owed: %s", $realtime,
                   results_seen, describe_outcome(out_item));
      end else begin
        want = outcomes_due.pop_front();
        if (out_item.status     !== want.status     ||
            out_item.ran_id     !== want.ran_id     ||
            out_item.ran_class  !== want.ran_class  ||
            out_item.now_time   !== want.now_time   ||
            out_item.wait_time  !== want.wait_time  ||
            out_item.turnaround !== want.turnaround) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result %0d mismatch\n  expected %s\n  actual   %s",
                     $realtime, results_seen, describe_outcome(want),
                     describe_outcome(out_item));
        end
      end
    end
  end

  // watchdog: too long without any item moving means the block is stuck
  int unsigned stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_MAX) begin
      $display("%0t: no progress for %0d cycles", $realtime, STUCK_MAX);
      $display("tb_two_level_round_robin_scheduler_core: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle tick, zero burst, extreme ids, rotation at the reset slice of three,
  // job change after a finish, low queue running once high is empty
  task automatic test_directed();
    send_item(tick_item());
    send_item(arrival_item(8'd0, CLS_HIGH, 16'd0));
    send_item(tick_item());
    send_item(arrival_item(8'd255, CLS_HIGH, 16'd5));
    send_item(arrival_item(8'd85, CLS_HIGH, 16'd1));
    send_item(arrival_item(8'd170, CLS_LOW, 16'd2));
    repeat (9) send_item(tick_item());
  endtask

  // fill both queues, one drop each, then run them empty across the wrap
  task automatic test_queue_full();
    for (int i = 0; i <= QDEPTH; i++)
      send_item(arrival_item(i[7:0], CLS_HIGH, TIME_W'($urandom_range(1, 3))));
    for (int i = 0; i <= QDEPTH; i++)
      send_item(arrival_item(8'(255 - i), CLS_LOW, TIME_W'($urandom_range(1, 3))));
    drain_queues();
    send_item(tick_item());
  endtask

  // random mix under one slice setting; arrivals back off as the queues fill
  task automatic test_random_phase(logic [7:0] slice, int unsigned n_items,
                                   int unsigned long_pct);
    in_item_t    it;
    int unsigned r;
    bit          arrive;
    wait_idle();
    write_slice(slice);
    repeat (n_items) begin
      if (q_cnt[CLS_HIGH] + q_cnt[CLS_LOW] >= 12) arrive = ($urandom_range(0, 9) == 0);
      else arrive = ($urandom_range(0, 99) < 45);
      if (arrive) begin
        r = $urandom_range(0, 99);
        it = arrival_item(ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          16'd1);
        if (r < long_pct) it.burst_length = TIME_W'($urandom_range(256, 700));
        else if (r < long_pct + 3) it.burst_length = '0;
        else if (r < 75) it.burst_length = TIME_W'($urandom_range(1, 4));
        else it.burst_length = TIME_W'($urandom_range(5, 24));
      end else begin
        it = tick_item();
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_queue_full();
    test_random_phase(8'd1, 400, 0);
    test_random_phase(8'd0, 400, 0);
    test_random_phase(8'd255, 300, 1);
    test_random_phase(8'd2, 400, 1);
    test_random_phase(RESET_SLICE, 500, 1);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && outcomes_due.size() == 0) begin
      $display("tb_two_level_round_robin_scheduler_core: PASS");
    end else begin
      $display("tb_two_level_round_robin_scheduler_core: FAIL");
    end
    $finish;
  end

endmodule
